### rtl/itcp_pkg.sv
// ----------------------------------------------------------------------------
// itcp_pkg
// Shared types, character codes and status codes of the infix calculator
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package itcp_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 64;

    localparam int CH_W     = 8;
    localparam int STATUS_W = 3;
    localparam int RESULT_W = 64;

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADNUM  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADOP   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_LEAD_A,
        PH_SIGN_A,
        PH_IN_A,
        PH_LEAD_OP,
        PH_LEAD_B,
        PH_SIGN_B,
        PH_IN_B,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_CHAR,
        SQ_ACC,
        SQ_FIN,
        SQ_MUL,
        SQ_DIV_A,
        SQ_DIV_B,
        SQ_DIV,
        SQ_DIV_FIX,
        SQ_OUT
    } seq_t;

    function automatic logic is_op_char(input logic [CH_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

    function automatic op_t op_of(input logic [CH_W-1:0] c);
        op_t op;
        op = OP_DIV;
        if (c == CH_PLUS)
        begin
            op = OP_ADD;
        end
        else if (c == CH_MINUS)
        begin
            op = OP_SUB;
        end
        else if (c == CH_STAR)
        begin
            op = OP_MUL;
        end
        return op;
    endfunction

endpackage

`default_nettype wire

### rtl/itcp_addsub.sv
// ----------------------------------------------------------------------------
// itcp_addsub
// Shared add/subtract unit with carry out; a carry out on subtract means
// no borrow.
// ----------------------------------------------------------------------------
`default_nettype none

module itcp_addsub #(
    parameter int WIDTH = 65
) (
    input  wire logic [WIDTH-1:0] x,
    input  wire logic [WIDTH-1:0] y,
    input  wire logic             sub,
    output logic      [WIDTH-1:0] sum,
    output logic                  cout
);

    logic [WIDTH-1:0] y_eff;

    assign y_eff = sub ? ~y : y;
    assign {cout, sum} = {1'b0, x} + {1'b0, y_eff} + {{WIDTH{1'b0}}, sub};

endmodule

`default_nettype wire

### rtl/infix_two_operand_calc_parser.sv
// ----------------------------------------------------------------------------
// infix_two_operand_calc_parser
// Parses "A op B" one character per transfer and evaluates it at end of line.
//
// Input stream: s_axis_tdata carries one character, s_axis_tlast marks end of
// line (the character is then ignored). Output stream: one transfer per end
// of line, m_axis_tuser holds the status, m_axis_tdata the signed result.
//
// All work goes through one shared add/subtract unit under a sequencer, and
// s_axis_tready is low while an item is in work, in these sequencer states:
//   space, sign, operator, first digit : CHAR
//   further digit (x10 then + digit)   : CHAR (5v), then ACC
//   end of line, + or - or error       : FIN (again if B is open), then OUT
//   end of line, *                     : FIN, MUL per bit, OUT
//   end of line, /                     : FIN, DIV_A/B, DIV per bit, DIV_FIX, OUT
// Multiply is shift-add and divide is restoring, one bit per cycle each.
// The result sits in an output register; the next line is accepted while it
// waits. If a second result is ready before the first is taken, the block
// holds and accepts nothing until the receiver takes the first.
// Reset clears the line state and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_two_operand_calc_parser #(
    parameter int VALUE_WIDTH = itcp_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [itcp_pkg::CH_W-1:0]     s_axis_tdata,   // [7:0] ch
    input  wire logic                          s_axis_tlast,   // end_of_line
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [itcp_pkg::RESULT_W-1:0] m_axis_tdata,   // [63:0] value
    output logic      [itcp_pkg::STATUS_W-1:0] m_axis_tuser    // [2:0] status
);

    import itcp_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W);

    seq_t              seq_reg, seq_next;
    phase_t            phase_reg, phase_next;
    op_t               op_reg, op_next;
    logic              minus_reg, minus_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic              nonempty_reg, nonempty_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [W-1:0]      a_reg, a_next;
    logic [W-1:0]      b_reg, b_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [W-1:0]      res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [RESULT_W-1:0] out_value_reg, out_value_next;

    logic [W:0]        alu_x, alu_y, alu_sum;
    logic              alu_sub, alu_cout;

    logic              accept, is_digit, is_space, is_minus, use_b, out_free;
    logic [3:0]        dig;
    logic [W-1:0]      cur;
    logic              fin_ok;

    itcp_addsub #(
        .WIDTH(W + 1)
    ) u_addsub (
        .x   (alu_x),
        .y   (alu_y),
        .sub (alu_sub),
        .sum (alu_sum),
        .cout(alu_cout)
    );

    assign s_axis_tready = (seq_reg == SQ_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    assign is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_space = (ch_reg == CH_SPACE);
    assign is_minus = (ch_reg == CH_MINUS);
    assign dig      = 4'(ch_reg - CH_ZERO);
    assign use_b    = (phase_reg == PH_LEAD_B) || (phase_reg == PH_SIGN_B) ||
                      (phase_reg == PH_IN_B);
    assign cur      = use_b ? b_reg : a_reg;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign fin_ok   = nonempty_reg && (err_reg == ST_OK);

    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    seq_next = s_axis_tlast ? SQ_FIN : SQ_CHAR;
                end
            end
            SQ_CHAR:
            begin
                if (is_digit && ((phase_reg == PH_IN_A) || (phase_reg == PH_IN_B)))
                begin
                    seq_next = SQ_ACC;
                end
                else
                begin
                    seq_next = SQ_IDLE;
                end
            end
            SQ_ACC:
            begin
                seq_next = SQ_IDLE;
            end
            SQ_FIN:
            begin
                if (fin_ok && (phase_reg == PH_IN_B))
                begin
                    seq_next = SQ_FIN;
                end
                else if (fin_ok && (phase_reg == PH_DONE) && (op_reg == OP_MUL))
                begin
                    seq_next = SQ_MUL;
                end
                else if (fin_ok && (phase_reg == PH_DONE) && (op_reg == OP_DIV) &&
                         (b_reg != '0))
                begin
                    seq_next = SQ_DIV_A;
                end
                else
                begin
                    seq_next = SQ_OUT;
                end
            end
            SQ_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    seq_next = SQ_OUT;
                end
            end
            SQ_DIV_A:
            begin
                seq_next = SQ_DIV_B;
            end
            SQ_DIV_B:
            begin
                seq_next = SQ_DIV;
            end
            SQ_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    seq_next = SQ_DIV_FIX;
                end
            end
            SQ_DIV_FIX:
            begin
                seq_next = SQ_OUT;
            end
            SQ_OUT:
            begin
                if (out_free)
                begin
                    seq_next = SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        op_next         = op_reg;
        minus_next      = minus_reg;
        err_next        = err_reg;
        nonempty_next   = nonempty_reg;
        ch_next         = ch_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        neg_next        = neg_reg;
        st_next         = st_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        alu_x           = '0;
        alu_y           = '0;
        alu_sub         = 1'b0;

        case (seq_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    ch_next = s_axis_tdata;
                    if (!s_axis_tlast)
                    begin
                        nonempty_next = 1'b1;
                    end
                end
            end
            SQ_CHAR:
            begin
                // digit: 4v + v, otherwise 0 - v for the sign
                alu_x   = is_digit ? {1'b0, cur[W-3:0], 2'b00} : '0;
                alu_y   = {1'b0, cur};
                alu_sub = !is_digit;
                case (phase_reg)
                    PH_LEAD_A, PH_SIGN_A, PH_LEAD_B, PH_SIGN_B:
                    begin
                        if (is_space && ((phase_reg == PH_LEAD_A) || (phase_reg == PH_LEAD_B)))
                        begin
                            phase_next = phase_reg;
                        end
                        else if (is_minus &&
                                 ((phase_reg == PH_LEAD_A) || (phase_reg == PH_LEAD_B)))
                        begin
                            minus_next = 1'b1;
                            phase_next = (phase_reg == PH_LEAD_A) ? PH_SIGN_A : PH_SIGN_B;
                        end
                        else if (!is_digit)
                        begin
                            err_next   = ST_BADNUM;
                            phase_next = PH_DONE;
                        end
                        else if (use_b)
                        begin
                            b_next     = W'(dig);
                            phase_next = PH_IN_B;
                        end
                        else
                        begin
                            a_next     = W'(dig);
                            phase_next = PH_IN_A;
                        end
                    end
                    PH_IN_A:
                    begin
                        if (is_digit)
                        begin
                            acc_next = alu_sum[W-1:0];
                        end
                        else
                        begin
                            a_next = minus_reg ? alu_sum[W-1:0] : a_reg;
                            if (is_space)
                            begin
                                phase_next = PH_LEAD_OP;
                            end
                            else if (is_op_char(ch_reg))
                            begin
                                op_next    = op_of(ch_reg);
                                minus_next = 1'b0;
                                phase_next = PH_LEAD_B;
                            end
                            else
                            begin
                                err_next   = ST_BADOP;
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    PH_LEAD_OP:
                    begin
                        if (!is_space)
                        begin
                            if (is_op_char(ch_reg))
                            begin
                                op_next    = op_of(ch_reg);
                                minus_next = 1'b0;
                                phase_next = PH_LEAD_B;
                            end
                            else
                            begin
                                err_next   = ST_BADOP;
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    PH_IN_B:
                    begin
                        if (is_digit)
                        begin
                            acc_next = alu_sum[W-1:0];
                        end
                        else
                        begin
                            b_next     = minus_reg ? alu_sum[W-1:0] : b_reg;
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            SQ_ACC:
            begin
                // 2 * (5v) + digit
                alu_x = {1'b0, acc_reg[W-2:0], 1'b0};
                alu_y = (W + 1)'(dig);
                if (use_b)
                begin
                    b_next = alu_sum[W-1:0];
                end
                else
                begin
                    a_next = alu_sum[W-1:0];
                end
            end
            SQ_FIN:
            begin
                alu_x    = {1'b0, a_reg};
                alu_y    = {1'b0, b_reg};
                res_next = '0;
                if (!nonempty_reg)
                begin
                    st_next = ST_EMPTY;
                end
                else if (err_reg != ST_OK)
                begin
                    st_next = err_reg;
                end
                else
                begin
                    case (phase_reg)
                        PH_LEAD_A, PH_SIGN_A, PH_LEAD_B, PH_SIGN_B:
                        begin
                            st_next = ST_BADNUM;
                        end
                        PH_IN_A, PH_LEAD_OP:
                        begin
                            st_next = ST_BADOP;
                        end
                        PH_IN_B:
                        begin
                            alu_x   = '0;
                            alu_sub = 1'b1;
                            if (minus_reg)
                            begin
                                b_next = alu_sum[W-1:0];
                            end
                            phase_next = PH_DONE;
                        end
                        default:
                        begin
                            st_next = ST_OK;
                            case (op_reg)
                                OP_ADD:
                                begin
                                    res_next = alu_sum[W-1:0];
                                end
                                OP_SUB:
                                begin
                                    alu_sub  = 1'b1;
                                    res_next = alu_sum[W-1:0];
                                end
                                OP_MUL:
                                begin
                                    acc_next = '0;
                                    cnt_next = CNT_W'(W - 1);
                                end
                                default:
                                begin
                                    if (b_reg == '0)
                                    begin
                                        st_next = ST_DIVZERO;
                                    end
                                    acc_next = '0;
                                    cnt_next = CNT_W'(W - 1);
                                    neg_next = a_reg[W-1] ^ b_reg[W-1];
                                end
                            endcase
                        end
                    endcase
                end
            end
            SQ_MUL:
            begin
                alu_x    = {1'b0, acc_reg};
                alu_y    = {1'b0, a_reg};
                acc_next = b_reg[0] ? alu_sum[W-1:0] : acc_reg;
                a_next   = {a_reg[W-2:0], 1'b0};
                b_next   = {1'b0, b_reg[W-1:1]};
                cnt_next = cnt_reg - 1'b1;
                res_next = acc_next;
                st_next  = ST_OK;
            end
            SQ_DIV_A:
            begin
                alu_y   = {1'b0, a_reg};
                alu_sub = 1'b1;
                if (a_reg[W-1])
                begin
                    a_next = alu_sum[W-1:0];
                end
            end
            SQ_DIV_B:
            begin
                alu_y   = {1'b0, b_reg};
                alu_sub = 1'b1;
                if (b_reg[W-1])
                begin
                    b_next = alu_sum[W-1:0];
                end
            end
            SQ_DIV:
            begin
                // restoring step: quotient bits shift into a from the right
                alu_x    = {acc_reg, a_reg[W-1]};
                alu_y    = {1'b0, b_reg};
                alu_sub  = 1'b1;
                acc_next = alu_cout ? alu_sum[W-1:0] : {acc_reg[W-2:0], a_reg[W-1]};
                a_next   = {a_reg[W-2:0], alu_cout};
                cnt_next = cnt_reg - 1'b1;
            end
            SQ_DIV_FIX:
            begin
                alu_y    = {1'b0, a_reg};
                alu_sub  = 1'b1;
                res_next = neg_reg ? alu_sum[W-1:0] : a_reg;
                st_next  = ST_OK;
            end
            SQ_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_value_next  = RESULT_W'($signed(res_reg));
                    phase_next      = PH_LEAD_A;
                    op_next         = OP_ADD;
                    minus_next      = 1'b0;
                    err_next        = ST_OK;
                    nonempty_next   = 1'b0;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_IDLE;
            phase_reg     <= PH_LEAD_A;
            op_reg        <= OP_ADD;
            minus_reg     <= 1'b0;
            err_reg       <= ST_OK;
            nonempty_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            minus_reg     <= minus_next;
            err_reg       <= err_next;
            nonempty_reg  <= nonempty_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        acc_reg        <= acc_next;
        neg_reg        <= neg_next;
        st_reg         <= st_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

endmodule

`default_nettype wire

### rtl/itcp_checker.sv
// ----------------------------------------------------------------------------
// itcp_checker
// Port-level checks of the infix calculator parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itcp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          s_axis_tlast,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [itcp_pkg::RESULT_W-1:0] m_axis_tdata,
    input wire logic [itcp_pkg::STATUS_W-1:0] m_axis_tuser
);

    import itcp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output dropped or changed while stalled");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous transfer in work");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("nonzero value with error status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_EMPTY))
        else $error("status code out of range");

    a_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid |=>
            !m_axis_tvalid)
        else $error("result produced by a character transfer");

endmodule

bind infix_two_operand_calc_parser itcp_checker u_itcp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
